[hw/rtl/crcfr_pkg.sv]
// crcfr_pkg: shared types, codes and the crc-16-ccitt byte update
// for the crc checked frame receiver. No dependencies.
package crcfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned HDR_BYTES  = 4;
    localparam logic [CRC_W-1:0] CCITT_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] SEED_RESET = 16'hFFFF;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'hFF;

    // configuration register indexes
    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_CRC_SEED    = 1'b1;

    // header byte positions
    localparam logic [1:0] HDR_CATEGORY = 2'd0;
    localparam logic [1:0] HDR_FLAGS    = 2'd1;
    localparam logic [1:0] HDR_SEQUENCE = 2'd2;
    localparam logic [1:0] HDR_LENGTH   = 2'd3;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SIZE = 2'd1,
        STATUS_CRC  = 2'd2
    } status_t;

    // one result transaction
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        status_t           status;
        logic [BYTE_W-1:0] category;
        logic [BYTE_W-1:0] frame_flags;
        logic [BYTE_W-1:0] sequence_res;
        logic [BYTE_W-1:0] payload_length;
        logic [CRC_W-1:0]  received_check;
        logic              last_result;
    } result_t;

    // results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res_a;
        result_t    res_b;
    } push_t;

    // one byte of crc-16-ccitt, msb first
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CCITT_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crcfr_parser.sv]
// crcfr_parser: frame parse state, configuration registers and result build.
// Depends on crcfr_pkg.
module crcfr_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  buf_last,
    output crcfr_pkg::push_t      push
);
    import crcfr_pkg::*;

    logic [BYTE_W-1:0] max_payload_reg;
    logic [CRC_W-1:0]  crc_seed_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] cat_reg, cat_next;
    logic [BYTE_W-1:0] flags_reg, flags_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] tlow_reg, tlow_next;
    logic              done_reg, done_next;

    logic [POS_W-1:0]  trailer_pos;
    logic [POS_W-1:0]  pay_off;
    logic [CRC_W-1:0]  chk;
    push_t             push_c;

    assign trailer_pos = POS_W'(HDR_BYTES) + {1'b0, len_reg};
    assign pay_off     = pos_reg - POS_W'(HDR_BYTES);
    assign chk         = {in_byte, tlow_reg};

    // parse step for one byte
    always_comb begin
        pos_next   = pos_reg;
        cat_next   = cat_reg;
        flags_next = flags_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        tlow_next  = tlow_reg;
        done_next  = done_reg;
        push_c     = '0;

        if (!done_reg) begin
            if (pos_reg < POS_W'(HDR_BYTES)) begin
                crc_next = crc_step((pos_reg == '0) ? crc_seed_reg : crc_reg, in_byte);
                case (pos_reg[1:0])
                    HDR_CATEGORY: cat_next   = in_byte;
                    HDR_FLAGS:    flags_next = in_byte;
                    HDR_SEQUENCE: seq_next   = in_byte;
                    HDR_LENGTH: begin
                        len_next = in_byte;
                        if (in_byte > max_payload_reg) begin
                            push_c.count                = 2'd1;
                            push_c.res_a.kind           = KIND_VERDICT;
                            push_c.res_a.status         = STATUS_SIZE;
                            push_c.res_a.category       = cat_reg;
                            push_c.res_a.frame_flags    = flags_reg;
                            push_c.res_a.sequence_res   = seq_reg;
                            push_c.res_a.payload_length = in_byte;
                            done_next                   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else if (pos_reg < trailer_pos) begin
                crc_next                   = crc_step(crc_reg, in_byte);
                push_c.count               = 2'd1;
                push_c.res_a.kind          = KIND_PAYLOAD;
                push_c.res_a.payload_byte  = in_byte;
                push_c.res_a.payload_index = pay_off[BYTE_W-1:0];
            end else if (pos_reg == trailer_pos) begin
                tlow_next = in_byte;
            end else begin
                push_c.count                = 2'd1;
                push_c.res_a.kind           = KIND_VERDICT;
                push_c.res_a.status         = (chk == crc_reg) ? STATUS_OK : STATUS_CRC;
                push_c.res_a.category       = cat_reg;
                push_c.res_a.frame_flags    = flags_reg;
                push_c.res_a.sequence_res   = seq_reg;
                push_c.res_a.payload_length = len_reg;
                push_c.res_a.received_check = chk;
                done_next                   = 1'b1;
            end
            if (!done_next) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        // buffer end: early-end verdict, then restart
        if (buf_last) begin
            if (!done_next) begin
                if (push_c.count == 2'd1) begin
                    push_c.count                = 2'd2;
                    push_c.res_b.kind           = KIND_VERDICT;
                    push_c.res_b.status         = STATUS_SIZE;
                    push_c.res_b.category       = cat_next;
                    push_c.res_b.frame_flags    = flags_next;
                    push_c.res_b.sequence_res   = seq_next;
                    push_c.res_b.payload_length = len_next;
                end else begin
                    push_c.count                = 2'd1;
                    push_c.res_a.kind           = KIND_VERDICT;
                    push_c.res_a.status         = STATUS_SIZE;
                    push_c.res_a.category       = cat_next;
                    push_c.res_a.frame_flags    = flags_next;
                    push_c.res_a.sequence_res   = seq_next;
                    push_c.res_a.payload_length = len_next;
                end
            end
            pos_next   = '0;
            cat_next   = '0;
            flags_next = '0;
            seq_next   = '0;
            len_next   = '0;
            crc_next   = crc_seed_reg;
            tlow_next  = '0;
            done_next  = 1'b0;
        end

        // flag the final result of this byte
        if (push_c.count == 2'd2) begin
            push_c.res_b.last_result = 1'b1;
        end else if (push_c.count == 2'd1) begin
            push_c.res_a.last_result = 1'b1;
        end
    end

    assign push = accept ? push_c : '0;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            crc_seed_reg    <= SEED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[BYTE_W-1:0];
                REG_CRC_SEED:    crc_seed_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cat_reg   <= '0;
            flags_reg <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            crc_reg   <= SEED_RESET;
            tlow_reg  <= '0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            cat_reg   <= cat_next;
            flags_reg <= flags_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            tlow_reg  <= tlow_next;
            done_reg  <= done_next;
        end
    end

endmodule

[hw/rtl/crcfr_result_fifo.sv]
// crcfr_result_fifo: four-entry result queue, up to two pushes per cycle.
// Depends on crcfr_pkg.
module crcfr_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crcfr_pkg::push_t      push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crcfr_pkg::result_t    out_res
);
    import crcfr_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd2);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.res_b;
        end
    end

endmodule

[hw/rtl/crc_checked_frame_receiver.sv]
// crc_checked_frame_receiver: top level, byte-stream frame parser with crc check.
// Depends on crcfr_pkg, crcfr_parser and crcfr_result_fifo.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    in_byte, buf_last
//  m_       out        m_valid/m_ready    kind ... last_result (one result each)
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// One byte accepted per cycle; its results land in a four-entry queue the
// cycle after. A byte gives at most two results, so s_ready drops while more
// than two entries wait. Sync active-low reset clears parse state and queue,
// and sets max_payload to 255 and crc_seed to 0xFFFF.
module crc_checked_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_buf_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [1:0]  m_status,
    output logic [7:0]  m_category,
    output logic [7:0]  m_frame_flags,
    output logic [7:0]  m_sequence_res,
    output logic [7:0]  m_payload_length,
    output logic [15:0] m_received_check,
    output logic        m_last_result
);
    import crcfr_pkg::*;

    push_t   push;
    result_t out_res;
    logic    room;
    logic    accept;

    assign s_ready = room;
    assign accept  = s_valid && room;

    // parser
    crcfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_in_byte),
        .buf_last  (s_buf_last),
        .push      (push)
    );

    // result queue
    crcfr_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    // result transaction fields
    assign m_kind           = out_res.kind;
    assign m_payload_byte   = out_res.payload_byte;
    assign m_payload_index  = out_res.payload_index;
    assign m_status         = out_res.status;
    assign m_category       = out_res.category;
    assign m_frame_flags    = out_res.frame_flags;
    assign m_sequence_res   = out_res.sequence_res;
    assign m_payload_length = out_res.payload_length;
    assign m_received_check = out_res.received_check;
    assign m_last_result    = out_res.last_result;

endmodule
